// ===== sv/i2cte_pkg.sv =====
// Types, constants and a helper function shared by the I2C edge-driven target.
`default_nettype none

package i2cte_pkg;

    localparam int TABLE_BYTES_DEFAULT = 8;
    localparam int OUT_FIFO_DEPTH      = 4;

    localparam logic [6:0]  OWN_ADDRESS_RESET    = 7'h0F;
    localparam logic [63:0] TRANSMIT_TABLE_RESET = 64'h0071_6151_4131_2111;

    localparam logic CFG_OWN_ADDRESS    = 1'b0;
    localparam logic CFG_TRANSMIT_TABLE = 1'b1;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    localparam logic [2:0] PHASE_CODE_IDLE       = 3'd0;
    localparam logic [2:0] PHASE_CODE_ADDRESS    = 3'd1;
    localparam logic [2:0] PHASE_CODE_OWN_ACK    = 3'd2;
    localparam logic [2:0] PHASE_CODE_MASTER_ACK = 3'd3;
    localparam logic [2:0] PHASE_CODE_SEND       = 3'd4;
    localparam logic [2:0] PHASE_CODE_RECEIVE    = 3'd5;
    localparam logic [2:0] PHASE_CODE_END        = 3'd6;

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_ADDRESS    = 7'b0000010,
        PH_OWN_ACK    = 7'b0000100,
        PH_MASTER_ACK = 7'b0001000,
        PH_SEND       = 7'b0010000,
        PH_RECEIVE    = 7'b0100000,
        PH_END        = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic clock_line_edge;
        logic new_level;
        logic other_level;
    } in_item_t;

    typedef struct packed {
        logic       data_release;
        logic       byte_done;
        logic [7:0] received_byte;
        logic [2:0] receive_slot;
        logic [2:0] send_slot;
        logic [2:0] phase;
    } out_item_t;

    typedef struct packed {
        phase_t     phase;
        logic       read_flag;
        logic [3:0] bit_count;
        logic [7:0] address_shift;
        logic [7:0] receive_shift;
        logic [2:0] receive_index;
        logic [2:0] send_index;
        logic       data_drive;
    } ctx_t;

    localparam ctx_t CTX_RESET = '{
        phase:         PH_IDLE,
        read_flag:     1'b0,
        bit_count:     4'd0,
        address_shift: 8'd0,
        receive_shift: 8'd0,
        receive_index: 3'd0,
        send_index:    3'd0,
        data_drive:    1'b1
    };

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            PH_IDLE:       code = PHASE_CODE_IDLE;
            PH_ADDRESS:    code = PHASE_CODE_ADDRESS;
            PH_OWN_ACK:    code = PHASE_CODE_OWN_ACK;
            PH_MASTER_ACK: code = PHASE_CODE_MASTER_ACK;
            PH_SEND:       code = PHASE_CODE_SEND;
            PH_RECEIVE:    code = PHASE_CODE_RECEIVE;
            PH_END:        code = PHASE_CODE_END;
            default:       code = PHASE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== sv/i2cte_ctx_ram.sv =====
// Single-entry context memory with a registered read and a written flag.
`default_nettype none

module i2cte_ctx_ram (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            rd_en,
    input  wire logic            wr_en,
    input  wire i2cte_pkg::ctx_t wr_data,
    output i2cte_pkg::ctx_t      rd_data
);
    import i2cte_pkg::*;

    ctx_t mem [0:0];
    ctx_t rd_data_reg;
    logic written_reg;
    logic rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[0] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= written_reg;
            end
        end
    end

    // An entry never written reads as the reset context.
    assign rd_data = rd_valid_reg ? rd_data_reg : CTX_RESET;

endmodule

`default_nettype wire

// ===== sv/i2cte_step.sv =====
// Next-context and result logic for one bus edge event.
`default_nettype none

module i2cte_step #(
    parameter int TABLE_BYTES = i2cte_pkg::TABLE_BYTES_DEFAULT
) (
    input  wire i2cte_pkg::ctx_t     ctx_cur,
    input  wire i2cte_pkg::in_item_t item,
    input  wire logic [6:0]      own_address,
    input  wire logic [63:0]     transmit_table,
    output i2cte_pkg::ctx_t      ctx_next,
    output i2cte_pkg::out_item_t result
);
    import i2cte_pkg::*;

    localparam logic [2:0] LAST_SLOT = 3'(TABLE_BYTES - 1);

    ctx_t       nxt;
    logic       done;
    logic [7:0] got;
    logic [2:0] slot;
    logic       table_bit;
    logic [2:0] bit_pos;

    assign bit_pos   = ~ctx_cur.bit_count[2:0];
    assign table_bit = transmit_table[{ctx_cur.send_index, bit_pos}];

    always_comb
    begin
        nxt  = ctx_cur;
        done = 1'b0;
        got  = 8'd0;
        slot = 3'd0;
        if (item.clock_line_edge)
        begin
            if (item.new_level)
            begin
                case (ctx_cur.phase)
                    PH_ADDRESS:
                    begin
                        if (!ctx_cur.bit_count[3])
                        begin
                            nxt.address_shift[bit_pos] = ctx_cur.address_shift[bit_pos]
                                                         | item.other_level;
                            nxt.bit_count = ctx_cur.bit_count + 4'd1;
                        end
                    end
                    PH_MASTER_ACK:
                    begin
                        nxt.phase = item.other_level ? PH_END : PH_SEND;
                    end
                    PH_RECEIVE:
                    begin
                        if (!ctx_cur.bit_count[3])
                        begin
                            nxt.receive_shift[bit_pos] = item.other_level;
                            nxt.bit_count = ctx_cur.bit_count + 4'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                case (ctx_cur.phase)
                    PH_ADDRESS:
                    begin
                        if (ctx_cur.bit_count == BITS_PER_BYTE)
                        begin
                            nxt.read_flag = ctx_cur.address_shift[0];
                            nxt.bit_count = 4'd0;
                            if (ctx_cur.address_shift[7:1] != own_address)
                            begin
                                nxt.phase      = PH_IDLE;
                                nxt.data_drive = 1'b1;
                            end
                            else
                            begin
                                nxt.phase      = PH_OWN_ACK;
                                nxt.data_drive = 1'b0;
                            end
                        end
                    end
                    PH_OWN_ACK:
                    begin
                        if (ctx_cur.read_flag)
                        begin
                            nxt.data_drive = table_bit;
                            nxt.bit_count  = ctx_cur.bit_count + 4'd1;
                            nxt.phase      = PH_SEND;
                        end
                        else
                        begin
                            nxt.data_drive = 1'b1;
                            nxt.phase      = PH_RECEIVE;
                        end
                    end
                    PH_SEND:
                    begin
                        if (!ctx_cur.bit_count[3])
                        begin
                            nxt.data_drive = table_bit;
                            nxt.bit_count  = ctx_cur.bit_count + 4'd1;
                        end
                        else
                        begin
                            nxt.bit_count  = 4'd0;
                            nxt.data_drive = 1'b1;
                            nxt.send_index = (ctx_cur.send_index == LAST_SLOT) ? 3'd0
                                             : ctx_cur.send_index + 3'd1;
                            nxt.phase      = PH_MASTER_ACK;
                        end
                    end
                    PH_RECEIVE:
                    begin
                        if (ctx_cur.bit_count == BITS_PER_BYTE)
                        begin
                            done              = 1'b1;
                            got               = ctx_cur.receive_shift;
                            slot              = ctx_cur.receive_index;
                            nxt.data_drive    = 1'b0;
                            nxt.bit_count     = 4'd0;
                            nxt.phase         = PH_OWN_ACK;
                            nxt.receive_index = ctx_cur.receive_index + 3'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (item.other_level)
        begin
            // Data line moved while the clock line is high: start or stop.
            if (item.new_level)
            begin
                if (ctx_cur.phase == PH_END)
                begin
                    nxt.phase = PH_IDLE;
                end
                else if (ctx_cur.phase == PH_RECEIVE && ctx_cur.bit_count == 4'd1)
                begin
                    nxt.phase = PH_IDLE;
                end
            end
            else if (ctx_cur.phase == PH_IDLE
                     || (ctx_cur.phase == PH_RECEIVE && ctx_cur.bit_count == 4'd1))
            begin
                nxt.address_shift = 8'd0;
                nxt.receive_index = 3'd0;
                nxt.send_index    = 3'd0;
                nxt.bit_count     = 4'd0;
                nxt.phase         = PH_ADDRESS;
                nxt.data_drive    = 1'b1;
            end
        end
    end

    assign ctx_next = nxt;

    always_comb
    begin
        result.data_release  = nxt.data_drive;
        result.byte_done     = done;
        result.received_byte = got;
        result.receive_slot  = slot;
        result.send_slot     = nxt.send_index;
        result.phase         = phase_code(nxt.phase);
    end

endmodule

`default_nettype wire

// ===== sv/i2cte_out_fifo.sv =====
// Small result queue that decouples the update pipeline from the output channel.
`default_nettype none

module i2cte_out_fifo #(
    parameter int DEPTH = i2cte_pkg::OUT_FIFO_DEPTH
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire i2cte_pkg::out_item_t       push_data,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output i2cte_pkg::out_item_t            out_data,
    output logic [$clog2(DEPTH + 1) - 1:0]  count
);
    import i2cte_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    out_item_t      entries [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entries[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < CW'(DEPTH))
        else $error("result queue written while full");

    a_push_pop_hold: assert property (@(posedge clk) disable iff (!rst_n)
        push && pop |=> $stable(count_reg))
        else $error("result queue count moved on simultaneous push and pop");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue count beyond its depth");

endmodule

`default_nettype wire

// ===== sv/i2c_target_edge_fsm.sv =====
// Top level of the I2C target that advances on bus edge events.
// Path: a result beat passes the update stage register and the result queue before it leaves.
// Throughput: one event per cycle while in_stall is low; the context memory read is registered and
// the update of the event just before is forwarded around it.
// Reset: the context memory reads as the idle context until first written,
// with no clearing pass; address and table registers take their default values.
`default_nettype none

module i2c_target_edge_fsm #(
    parameter int TABLE_BYTES = i2cte_pkg::TABLE_BYTES_DEFAULT,
    parameter int OUT_DEPTH   = i2cte_pkg::OUT_FIFO_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire i2cte_pkg::in_item_t in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output i2cte_pkg::out_item_t  out_data,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [63:0]      cfg_data
);
    import i2cte_pkg::*;

    localparam int CW = $clog2(OUT_DEPTH + 1);

    logic [6:0]  own_address_reg;
    logic [63:0] transmit_table_reg;

    logic        accept;
    logic        s1_valid_reg;
    in_item_t    s1_item_reg;
    logic        fwd_en_reg;
    ctx_t        fwd_ctx_reg;
    ctx_t        ram_rd_data;
    ctx_t        ctx_cur;
    ctx_t        ctx_next;
    out_item_t   result;
    logic [CW-1:0] fifo_count;
    logic [CW:0]   occupancy;

    assign occupancy = {1'b0, fifo_count} + (CW + 1)'(s1_valid_reg);
    assign in_stall  = (occupancy >= (CW + 1)'(OUT_DEPTH));
    assign accept    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg    <= OWN_ADDRESS_RESET;
            transmit_table_reg <= TRANSMIT_TABLE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_ADDRESS:    own_address_reg    <= cfg_data[6:0];
                CFG_TRANSMIT_TABLE: transmit_table_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_en_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            fwd_en_reg   <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_data;
        end
        if (s1_valid_reg)
        begin
            fwd_ctx_reg <= ctx_next;
        end
    end

    // The write of the previous event lands on the same edge as this read.
    assign ctx_cur = fwd_en_reg ? fwd_ctx_reg : ram_rd_data;

    i2cte_ctx_ram u_ctx_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .wr_en   (s1_valid_reg),
        .wr_data (ctx_next),
        .rd_data (ram_rd_data)
    );

    i2cte_step #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_step (
        .ctx_cur        (ctx_cur),
        .item           (s1_item_reg),
        .own_address    (own_address_reg),
        .transmit_table (transmit_table_reg),
        .ctx_next       (ctx_next),
        .result         (result)
    );

    i2cte_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (result),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .count     (fifo_count)
    );

    a_accept_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted event did not reach the update stage");

    a_ack_with_byte: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && result.byte_done |-> !result.data_release)
        else $error("received byte reported without pulling the data line low");

    a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= (CW + 1)'(OUT_DEPTH))
        else $error("events in flight exceed the result queue depth");

endmodule

`default_nettype wire

// ===== test/i2c_target_checker.sv =====
// Checker that predicts every result beat of the I2C edge target and compares it.
`timescale 1ns / 100ps

module i2c_target_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  i2cte_pkg::in_item_t  in_data,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  i2cte_pkg::out_item_t out_data,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [63:0]          cfg_data,
    output int                   error_count,
    output int                   pending_count
);
    import i2cte_pkg::*;

    logic [6:0]  tgt_addr;
    logic [63:0] tx_bytes;
    logic [2:0]  bus_phase;
    logic        is_read;
    logic [3:0]  bits_seen;
    logic [7:0]  addr_bits;
    logic [7:0]  rx_bits;
    logic [2:0]  rx_slot;
    logic [2:0]  tx_slot;
    logic        sda_out;
    out_item_t   expected_beats[$];

    function automatic logic table_bit();
        return tx_bytes[{tx_slot, 3'd7 - bits_seen[2:0]}];
    endfunction

    function automatic out_item_t advance_target(input in_item_t ev);
        out_item_t res;
        res = '0;
        if (ev.clock_line_edge)
        begin
            if (ev.new_level)
            begin
                case (bus_phase)
                    PHASE_CODE_ADDRESS:
                    begin
                        if (bits_seen < BITS_PER_BYTE)
                        begin
                            addr_bits[3'd7 - bits_seen[2:0]] =
                                addr_bits[3'd7 - bits_seen[2:0]] | ev.other_level;
                            bits_seen = bits_seen + 4'd1;
                        end
                    end
                    PHASE_CODE_MASTER_ACK:
                    begin
                        bus_phase = ev.other_level ? PHASE_CODE_END : PHASE_CODE_SEND;
                    end
                    PHASE_CODE_RECEIVE:
                    begin
                        if (bits_seen < BITS_PER_BYTE)
                        begin
                            rx_bits[3'd7 - bits_seen[2:0]] = ev.other_level;
                            bits_seen = bits_seen + 4'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                case (bus_phase)
                    PHASE_CODE_ADDRESS:
                    begin
                        if (bits_seen == BITS_PER_BYTE)
                        begin
                            is_read = addr_bits[0];
                            bits_seen = 4'd0;
                            if (addr_bits[7:1] != tgt_addr)
                            begin
                                bus_phase = PHASE_CODE_IDLE;
                                sda_out = 1'b1;
                            end
                            else
                            begin
                                bus_phase = PHASE_CODE_OWN_ACK;
                                sda_out = 1'b0;
                            end
                        end
                    end
                    PHASE_CODE_OWN_ACK:
                    begin
                        if (is_read)
                        begin
                            sda_out = table_bit();
                            bits_seen = bits_seen + 4'd1;
                            bus_phase = PHASE_CODE_SEND;
                        end
                        else
                        begin
                            sda_out = 1'b1;
                            bus_phase = PHASE_CODE_RECEIVE;
                        end
                    end
                    PHASE_CODE_SEND:
                    begin
                        if (bits_seen < BITS_PER_BYTE)
                        begin
                            sda_out = table_bit();
                            bits_seen = bits_seen + 4'd1;
                        end
                        else
                        begin
                            bits_seen = 4'd0;
                            sda_out = 1'b1;
                            tx_slot = tx_slot + 3'd1;
                            bus_phase = PHASE_CODE_MASTER_ACK;
                        end
                    end
                    PHASE_CODE_RECEIVE:
                    begin
                        if (bits_seen == BITS_PER_BYTE)
                        begin
                            res.byte_done = 1'b1;
                            res.received_byte = rx_bits;
                            res.receive_slot = rx_slot;
                            sda_out = 1'b0;
                            bits_seen = 4'd0;
                            bus_phase = PHASE_CODE_OWN_ACK;
                            rx_slot = rx_slot + 3'd1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (ev.new_level)
        begin
            if ((bus_phase == PHASE_CODE_END && ev.other_level) ||
                (bus_phase == PHASE_CODE_RECEIVE && ev.other_level && bits_seen == 4'd1))
            begin
                bus_phase = PHASE_CODE_IDLE;
            end
        end
        else if ((bus_phase == PHASE_CODE_IDLE && ev.other_level) ||
                 (bus_phase == PHASE_CODE_RECEIVE && ev.other_level && bits_seen == 4'd1))
        begin
            addr_bits = 8'd0;
            rx_slot = 3'd0;
            tx_slot = 3'd0;
            bits_seen = 4'd0;
            bus_phase = PHASE_CODE_ADDRESS;
            sda_out = 1'b1;
        end
        res.data_release = sda_out;
        res.send_slot = tx_slot;
        res.phase = bus_phase;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            tgt_addr = OWN_ADDRESS_RESET;
            tx_bytes = TRANSMIT_TABLE_RESET;
            bus_phase = PHASE_CODE_IDLE;
            is_read = 1'b0;
            bits_seen = 4'd0;
            addr_bits = 8'd0;
            rx_bits = 8'd0;
            rx_slot = 3'd0;
            tx_slot = 3'd0;
            sda_out = 1'b1;
            expected_beats.delete();
            error_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_OWN_ADDRESS)
                begin
                    tgt_addr = cfg_data[6:0];
                end
                else
                begin
                    tx_bytes = cfg_data;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result beat: release=%0b done=%0b byte=%02h",
                             $time, out_data.data_release, out_data.byte_done,
                             out_data.received_byte,
                             " rslot=%0d sslot=%0d phase=%0d",
                             out_data.receive_slot, out_data.send_slot, out_data.phase);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (out_data !== want)
                    begin
                        error_count++;
                        $display("%0t: expected release=%0b done=%0b byte=%02h",
                                 $time, want.data_release, want.byte_done,
                                 want.received_byte,
                                 " rslot=%0d sslot=%0d phase=%0d",
                                 want.receive_slot, want.send_slot, want.phase);
                        $display("%0t:      got release=%0b done=%0b byte=%02h",
                                 $time, out_data.data_release, out_data.byte_done,
                                 out_data.received_byte,
                                 " rslot=%0d sslot=%0d phase=%0d",
                                 out_data.receive_slot, out_data.send_slot,
                                 out_data.phase);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_beats.push_back(advance_target(in_data));
            end
        end
        pending_count = expected_beats.size();
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the testbench: bus event stimulus, configuration phases and the verdict.
`timescale 1ns / 100ps

module tb_top;
    import i2cte_pkg::*;

    localparam int   CLK_PERIOD    = 20;
    localparam int   ITEM_COUNT    = 1300;
    localparam int   SETTING_SPAN  = 280;
    localparam int   HOLD_AT       = 400;
    localparam int   HOLD_CYCLES   = 150;
    localparam int   SETTLE_CYCLES = 6;
    localparam int   CYCLE_LIMIT   = 500000;
    localparam logic CLOCK_LINE    = 1'b1;
    localparam logic DATA_LINE     = 1'b0;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_OWN_ADDRESS;
    logic [63:0] cfg_data  = '0;

    int          error_count;
    int          pending_results;
    int          events_sent   = 0;
    int          cycle_count   = 0;
    logic        steady_sender = 1'b0;
    logic        bus_scl       = 1'b1;
    logic        bus_sda       = 1'b1;
    logic [6:0]  own_addr_now  = OWN_ADDRESS_RESET;

    i2c_target_edge_fsm dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    i2c_target_checker target_watch (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_results)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 25);
    endfunction

    task automatic push_event(input in_item_t ev);
        int gap;
        gap = steady_sender ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        events_sent++;
    endtask

    task automatic raw_event(input in_item_t ev);
        if (ev.clock_line_edge)
        begin
            bus_scl = ev.new_level;
            bus_sda = ev.other_level;
        end
        else
        begin
            bus_sda = ev.new_level;
            bus_scl = ev.other_level;
        end
        push_event(ev);
    endtask

    task automatic line_event(input logic is_clk, input logic lvl);
        in_item_t ev;
        ev.clock_line_edge = is_clk;
        ev.new_level = lvl;
        ev.other_level = is_clk ? bus_sda : bus_scl;
        raw_event(ev);
    endtask

    task automatic bus_bit(input logic value);
        if (bus_scl)
        begin
            line_event(CLOCK_LINE, 1'b0);
        end
        if (bus_sda != value)
        begin
            line_event(DATA_LINE, value);
        end
        line_event(CLOCK_LINE, 1'b1);
    endtask

    task automatic bus_byte(input logic [7:0] value);
        int k;
        for (k = 7; k >= 0; k--)
        begin
            bus_bit(value[k]);
        end
    endtask

    task automatic bus_start();
        if (bus_scl && !bus_sda)
        begin
            line_event(CLOCK_LINE, 1'b0);
        end
        if (!bus_sda)
        begin
            line_event(DATA_LINE, 1'b1);
        end
        if (!bus_scl)
        begin
            line_event(CLOCK_LINE, 1'b1);
        end
        line_event(DATA_LINE, 1'b0);
    endtask

    task automatic bus_stop();
        if (bus_sda)
        begin
            if (bus_scl)
            begin
                line_event(CLOCK_LINE, 1'b0);
            end
            line_event(DATA_LINE, 1'b0);
        end
        if (!bus_scl)
        begin
            line_event(CLOCK_LINE, 1'b1);
        end
        line_event(DATA_LINE, 1'b1);
    endtask

    // The acknowledge slot of a write is mostly driven low like the target's ack; on a read
    // the master mostly acks every byte but the last one, with random exceptions both ways.
    task automatic bus_transfer(input logic [6:0] dest, input logic rd, input int nbytes);
        int i;
        int pick;
        logic [7:0] value;
        logic ack_level;
        bus_start();
        bus_byte({dest, rd});
        bus_bit(1'b0);
        for (i = 0; i < nbytes; i++)
        begin
            pick = $urandom_range(0, 3);
            value = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
            bus_byte(value);
            if (rd)
            begin
                ack_level = (i == nbytes - 1) ? ($urandom_range(0, 9) != 0)
                                              : ($urandom_range(0, 19) == 0);
            end
            else
            begin
                ack_level = ($urandom_range(0, 9) == 0);
            end
            bus_bit(ack_level);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // The receiver stalls at random; once it holds off for a long stretch while
    // event beats keep coming, so the block backs up and stalls its input.
    initial
    begin
        int stall_len;
        logic held_long;
        held_long = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held_long && events_sent >= HOLD_AT)
            begin
                held_long = 1'b1;
                stall_len = HOLD_CYCLES;
            end
            else
            begin
                stall_len = pick_gap();
            end
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
            begin
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int k;
        int kind;
        int nbytes;
        int setting_no;
        int next_setting_at;
        logic [6:0] dest_addr;
        logic [63:0] table_now;
        setting_no = 0;
        next_setting_at = SETTING_SPAN;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < 8; k++)
        begin
            raw_event(in_item_t'(k[2:0]));
        end
        bus_stop();

        while (events_sent < ITEM_COUNT)
        begin
            if (events_sent >= next_setting_at)
            begin
                next_setting_at += SETTING_SPAN;
                setting_no++;
                in_valid <= 1'b0;
                @(posedge clk);
                wait (pending_results == 0);
                repeat (SETTLE_CYCLES) @(posedge clk);
                case (setting_no)
                    1:
                    begin
                        own_addr_now = 7'h00;
                        table_now = '0;
                    end
                    2:
                    begin
                        own_addr_now = 7'h7F;
                        table_now = '1;
                    end
                    3:
                    begin
                        own_addr_now = 7'($urandom);
                        table_now = {$urandom, $urandom};
                    end
                    default:
                    begin
                        own_addr_now = OWN_ADDRESS_RESET;
                        table_now = TRANSMIT_TABLE_RESET;
                    end
                endcase
                write_reg(CFG_OWN_ADDRESS, {57'd0, own_addr_now});
                write_reg(CFG_TRANSMIT_TABLE, table_now);
            end

            if (steady_sender)
            begin
                steady_sender = ($urandom_range(0, 2) != 0);
            end
            else
            begin
                steady_sender = ($urandom_range(0, 11) == 0);
            end

            kind = $urandom_range(0, 99);
            if (kind < 8)
            begin
                repeat ($urandom_range(1, 6)) raw_event(in_item_t'(3'($urandom)));
            end
            else if (kind < 18)
            begin
                bus_start();
                if ($urandom_range(0, 1) != 0)
                begin
                    bus_byte({own_addr_now, 1'($urandom)});
                end
                repeat ($urandom_range(1, 12)) bus_bit(1'($urandom));
                if ($urandom_range(0, 1) != 0)
                begin
                    bus_stop();
                end
            end
            else
            begin
                dest_addr = ($urandom_range(0, 3) != 0) ? own_addr_now : 7'($urandom);
                nbytes = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 11)
                                                     : $urandom_range(1, 4);
                bus_transfer(dest_addr, 1'($urandom), nbytes);
                if ($urandom_range(0, 2) != 0)
                begin
                    bus_stop();
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results == 0);
        repeat (8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/i2cte_pkg.sv
sv/i2cte_ctx_ram.sv
sv/i2cte_step.sv
sv/i2cte_out_fifo.sv
sv/i2c_target_edge_fsm.sv
test/i2c_target_checker.sv
test/tb_top.sv
